// ----- rtl/core/ideq_pkg.sv -----
package ideq_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_BACK   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_INSERT     = 3'd4,
		CMD_ERASE      = 3'd5,
		CMD_GET        = 3'd6,
		CMD_SET        = 3'd7
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PLAN   = 5'b00010,
		ST_MOVE   = 5'b00100,
		ST_ACCESS = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	localparam int unsigned CMD_W  = 3;
	localparam int unsigned POS_W  = 7;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CNT_W  = 7;

endpackage

// ----- rtl/core/ideq_mem.sv -----
module ideq_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6,
	parameter int unsigned DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/indexed_double_ended_array.sv -----
// Ordered list of up to CAPACITY signed 32-bit words with push/pop at both
// ends, insert/erase at an index and get/set at an index. One transfer in
// gives one transfer out. The words live in a simple dual-port memory (one
// write and one registered read per cycle), so the cost of an item is set by
// how many words it moves: get, set, pops and pushes with room move none,
// an insert, an erase or a recentring push moves N words (N <= CAPACITY - 1),
// and any wait on out_stall adds to it. The next transfer in can be taken
// while the result is shown, even while that result still waits to be taken.
// Failing commands leave the list unchanged; a failed get returns -1.
module indexed_double_ended_array
	import ideq_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         command,
	input  logic [POS_W-1:0]         position,
	input  logic signed [WORD_W-1:0] word_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     ok,
	output logic signed [WORD_W-1:0] word_out,
	output logic [CNT_W-1:0]         count
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
	localparam logic [CW-1:0] HALF_C = CW'(CAPACITY / 2);
	localparam logic [CW-1:0] ONE_C  = CW'(1);

	state_t state_q;

	cmd_t              cmd_q;
	logic [POS_W-1:0]  pos_q;
	logic [WORD_W-1:0] word_q;
	logic [CW-1:0]     head_q;
	logic [CW-1:0]     count_q;

	// plan of the current item
	logic          okp_q;
	logic          wr_q;
	logic [AW-1:0] waddr_q;
	logic          rd_q;
	logic [AW-1:0] raddr_q;
	logic          rfail_q;

	// block mover
	logic [CW-1:0] rd_ptr_q;
	logic [CW-1:0] wr_ptr_q;
	logic [CW-1:0] rem_q;
	logic          desc_q;
	logic          wpend_s1;

	logic              out_valid_q;
	logic              ok_q;
	logic [WORD_W-1:0] word_out_q;
	logic [CNT_W-1:0]  count_out_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [WORD_W-1:0] mem_rdata;

	// plan logic
	logic [PW-1:0]   pos_x;
	logic [PW-1:0]   cnt_x;
	logic [CW-1:0]   pos_c;
	logic            full;
	logic            empty;
	logic            tail_zero;
	logic [CW-1:0]   cap_less;
	logic [CW-1:0]   pb_head;
	logic [CW-1:0]   pf_base;
	logic [CW:0]     two_i;
	logic [CW:0]     cnt_m1;
	logic            do_back;
	logic            do_front;
	logic            p_ok;
	logic            p_move;
	logic [CW-1:0]   p_src;
	logic [CW-1:0]   p_dst;
	logic [CW-1:0]   p_len;
	logic            p_desc;
	logic            p_write;
	logic [CW-1:0]   p_waddr;
	logic            p_read;
	logic [CW-1:0]   p_raddr;
	logic            p_rfail;
	logic [CW-1:0]   p_head;
	logic [CW-1:0]   p_count;
	logic            out_free;

	assign pos_x     = PW'(pos_q);
	assign cnt_x     = PW'(count_q);
	assign pos_c     = CW'(pos_x);
	assign full      = (count_q == CAP_C);
	assign empty     = (count_q == '0);
	assign tail_zero = ((head_q + count_q) == CAP_C);
	assign cap_less  = CAP_C - count_q;
	assign pb_head   = cap_less >> 1;
	assign pf_base   = CW'(({1'b0, cap_less} + (CW+1)'(1)) >> 1);
	assign two_i     = {pos_c, 1'b0};
	assign cnt_m1    = {1'b0, count_q - ONE_C};

	always_comb begin
		do_back  = 1'b0;
		do_front = 1'b0;
		p_ok     = 1'b0;
		p_move   = 1'b0;
		p_src    = head_q;
		p_dst    = head_q;
		p_len    = '0;
		p_desc   = 1'b0;
		p_write  = 1'b0;
		p_waddr  = head_q;
		p_read   = 1'b0;
		p_raddr  = head_q;
		p_rfail  = 1'b0;
		p_head   = head_q;
		p_count  = count_q;
		case (cmd_q)
			CMD_PUSH_BACK: begin
				do_back = 1'b1;
			end
			CMD_PUSH_FRONT: begin
				do_front = 1'b1;
			end
			CMD_POP_BACK: begin
				if (!empty) begin
					p_ok    = 1'b1;
					p_count = count_q - ONE_C;
					p_head  = (count_q == ONE_C) ? HALF_C : head_q;
				end
			end
			CMD_POP_FRONT: begin
				if (!empty) begin
					p_ok    = 1'b1;
					p_count = count_q - ONE_C;
					p_head  = (count_q == ONE_C) ? HALF_C : head_q + ONE_C;
				end
			end
			CMD_INSERT: begin
				if (pos_x <= cnt_x && !full) begin
					if (pos_x == '0) begin
						do_front = 1'b1;
					end else if (pos_x == cnt_x) begin
						do_back = 1'b1;
					end else begin
						p_ok    = 1'b1;
						p_move  = 1'b1;
						p_write = 1'b1;
						p_count = count_q + ONE_C;
						if ((two_i <= cnt_m1 || tail_zero) && head_q != '0) begin
							p_head  = head_q - ONE_C;
							p_src   = head_q;
							p_dst   = head_q - ONE_C;
							p_len   = pos_c;
							p_waddr = head_q - ONE_C + pos_c;
						end else begin
							p_src   = head_q + pos_c;
							p_dst   = head_q + pos_c + ONE_C;
							p_len   = count_q - pos_c;
							p_desc  = 1'b1;
							p_waddr = head_q + pos_c;
						end
					end
				end
			end
			CMD_ERASE: begin
				if (pos_x < cnt_x) begin
					p_ok    = 1'b1;
					p_move  = 1'b1;
					p_count = count_q - ONE_C;
					if (two_i < cnt_m1) begin
						p_src  = head_q;
						p_dst  = head_q + ONE_C;
						p_len  = pos_c;
						p_desc = 1'b1;
						p_head = head_q + ONE_C;
					end else begin
						p_src = head_q + pos_c + ONE_C;
						p_dst = head_q + pos_c;
						p_len = count_q - ONE_C - pos_c;
					end
					if (count_q == ONE_C) begin
						p_head = HALF_C;
					end
				end
			end
			CMD_GET: begin
				if (pos_x < cnt_x) begin
					p_ok    = 1'b1;
					p_read  = 1'b1;
					p_raddr = head_q + pos_c;
				end else begin
					p_rfail = 1'b1;
				end
			end
			CMD_SET: begin
				if (pos_x < cnt_x) begin
					p_ok    = 1'b1;
					p_write = 1'b1;
					p_waddr = head_q + pos_c;
				end
			end
			default: begin
			end
		endcase

		if (do_back && !full) begin
			p_ok    = 1'b1;
			p_write = 1'b1;
			p_count = count_q + ONE_C;
			if (tail_zero) begin
				p_move  = 1'b1;
				p_src   = head_q;
				p_dst   = pb_head;
				p_len   = count_q;
				p_desc  = (pb_head > head_q);
				p_head  = pb_head;
				p_waddr = pb_head + count_q;
			end else begin
				p_waddr = head_q + count_q;
			end
		end

		if (do_front && !full) begin
			p_ok    = 1'b1;
			p_write = 1'b1;
			p_count = count_q + ONE_C;
			if (head_q == '0) begin
				p_move  = 1'b1;
				p_src   = head_q;
				p_dst   = pf_base;
				p_len   = count_q;
				p_desc  = 1'b1;
				p_head  = pf_base - ONE_C;
				p_waddr = pf_base - ONE_C;
			end else begin
				p_head  = head_q - ONE_C;
				p_waddr = head_q - ONE_C;
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// memory port: the mover owns it in ST_MOVE, the final access in ST_ACCESS.
	// Copy direction is picked so that no read meets an entry already overwritten.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_ptr_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = rd_ptr_q[AW-1:0];
		case (state_q)
			ST_MOVE: begin
				mem_we = wpend_s1;
				mem_re = (rem_q != '0);
			end
			ST_ACCESS: begin
				mem_we    = wr_q;
				mem_waddr = waddr_q;
				mem_wdata = word_q;
				mem_re    = rd_q;
				mem_raddr = raddr_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= HALF_C;
			count_q  <= '0;
			wpend_s1 <= 1'b0;
			rem_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_PLAN;
					end
				end
				ST_PLAN: begin
					head_q  <= p_head;
					count_q <= p_count;
					rem_q   <= p_move ? p_len : '0;
					state_q <= (p_move && p_len != '0) ? ST_MOVE : ST_ACCESS;
				end
				ST_MOVE: begin
					if (rem_q != '0) begin
						rem_q    <= rem_q - ONE_C;
						wpend_s1 <= 1'b1;
					end else begin
						wpend_s1 <= 1'b0;
						if (!wpend_s1) begin
							state_q <= ST_ACCESS;
						end
					end
				end
				ST_ACCESS: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q  <= cmd_t'(command);
			pos_q  <= position;
			word_q <= word_in;
		end
		if (state_q == ST_PLAN) begin
			okp_q    <= p_ok;
			wr_q     <= p_write;
			waddr_q  <= p_waddr[AW-1:0];
			rd_q     <= p_read;
			raddr_q  <= p_raddr[AW-1:0];
			rfail_q  <= p_rfail;
			desc_q   <= p_desc;
			rd_ptr_q <= p_desc ? p_src + p_len - ONE_C : p_src;
			wr_ptr_q <= p_desc ? p_dst + p_len - ONE_C : p_dst;
		end
		if (state_q == ST_MOVE) begin
			if (rem_q != '0) begin
				rd_ptr_q <= desc_q ? rd_ptr_q - ONE_C : rd_ptr_q + ONE_C;
			end
			if (wpend_s1) begin
				wr_ptr_q <= desc_q ? wr_ptr_q - ONE_C : wr_ptr_q + ONE_C;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			ok_q        <= okp_q;
			word_out_q  <= rd_q ? mem_rdata : (rfail_q ? '1 : '0);
			count_out_q <= CNT_W'(count_q);
		end
	end

	ideq_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.DW    (WORD_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign word_out  = word_out_q;
	assign count     = count_out_q;

endmodule
